FILE: hdl/qtc_pkg.sv
// ============================================================================
// qtc_pkg: shared types and constants for the quintic coefficient engine
// Field widths, default fraction widths, pipeline sideband and helpers.
// ============================================================================
package qtc_pkg;

    localparam int IN_W                  = 32;
    localparam int DUR_W                 = 23;
    localparam int COEF_W                = 64;
    localparam int QUO_W                 = COEF_W;
    localparam int IN_FRAC_BITS_DEFAULT  = 16;
    localparam int OUT_FRAC_BITS_DEFAULT = 32;

    // Values that ride alongside an item for the whole pipeline.
    typedef struct packed {
        logic signed [IN_W-1:0] sp;
        logic signed [IN_W-1:0] sv;
        logic signed [IN_W-1:0] sa;
        logic [DUR_W-1:0]       dur;
    } t_side;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Rescales a fixed-point value by 2^sh, truncating toward zero when sh < 0.
    function automatic logic signed [COEF_W-1:0] scale_fix(
        input logic signed [IN_W-1:0] x, input int sh);
        logic signed [COEF_W-1:0] ext;
        logic signed [COEF_W-1:0] bias;
        ext  = {{(COEF_W-IN_W){x[IN_W-1]}}, x};
        bias = '0;
        if (sh >= 0) begin
            return ext <<< sh;
        end
        if (x[IN_W-1]) begin
            bias = (COEF_W'(1) <<< (-sh)) - COEF_W'(1);
        end
        return (ext + bias) >>> (-sh);
    endfunction

endpackage

FILE: hdl/qtc_if.sv
// ============================================================================
// qtc_if: valid/ready channels of the quintic coefficient engine
// One interface for the boundary-state transaction, one for the result.
// ============================================================================
interface qtc_in_if;
    logic valid;
    logic ready;
    logic signed [qtc_pkg::IN_W-1:0] start_position;
    logic signed [qtc_pkg::IN_W-1:0] start_velocity;
    logic signed [qtc_pkg::IN_W-1:0] start_accel;
    logic signed [qtc_pkg::IN_W-1:0] goal_position;
    logic signed [qtc_pkg::IN_W-1:0] goal_velocity;
    logic signed [qtc_pkg::IN_W-1:0] goal_accel;
    logic [qtc_pkg::DUR_W-1:0]       duration;

    modport source (output valid, start_position, start_velocity, start_accel,
                    goal_position, goal_velocity, goal_accel, duration,
                    input ready);
    modport sink   (input valid, start_position, start_velocity, start_accel,
                    goal_position, goal_velocity, goal_accel, duration,
                    output ready);
endinterface

interface qtc_out_if;
    logic valid;
    logic ready;
    logic signed [qtc_pkg::COEF_W-1:0] coef_0;
    logic signed [qtc_pkg::COEF_W-1:0] coef_1;
    logic signed [qtc_pkg::COEF_W-1:0] coef_2;
    logic signed [qtc_pkg::COEF_W-1:0] coef_3;
    logic signed [qtc_pkg::COEF_W-1:0] coef_4;
    logic signed [qtc_pkg::COEF_W-1:0] coef_5;
    logic                              invalid;

    modport source (output valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5,
                    invalid, input ready);
    modport sink   (input valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5,
                    invalid, output ready);
endinterface

FILE: hdl/qtc_div.sv
// ============================================================================
// qtc_div: pipelined restoring divider with signed saturation
// Divides a magnitude by a positive denominator, one quotient bit per stage,
// then applies the sign and clamps to the signed quotient range.
// ============================================================================
module qtc_div #(
    parameter int NUM_W = 100,
    parameter int DEN_W = 70,
    parameter int QUO_W = qtc_pkg::QUO_W
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [NUM_W-1:0]        i_mag,
    input  logic                    i_neg,
    input  logic [DEN_W-1:0]        i_den,
    output logic signed [QUO_W-1:0] o_quo
);

    localparam int REM_W = qtc_pkg::imax(NUM_W, DEN_W + QUO_W);
    localparam int CMP_W = qtc_pkg::imax(NUM_W, DEN_W);

    logic [REM_W-1:0] r_rem [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_q   [0:QUO_W];
    logic             r_neg [0:QUO_W];
    logic             r_ovf [0:QUO_W];

    // The quotient overflows its width exactly when mag >= den * 2^QUO_W.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= REM_W'(i_mag);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= i_neg;
            r_ovf[0] <= CMP_W'(i_mag >> QUO_W) >= CMP_W'(i_den);
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        localparam int BIT = QUO_W - k;
        logic [REM_W:0]   sub;
        logic [REM_W-1:0] n_rem;
        logic [QUO_W-1:0] n_q;

        always_comb begin
            sub = {1'b0, r_rem[k-1]} - ({1'b0, REM_W'(r_den[k-1])} << BIT);
            if (sub[REM_W]) begin
                n_rem = r_rem[k-1];
                n_q   = r_q[k-1];
            end else begin
                n_rem = sub[REM_W-1:0];
                n_q   = r_q[k-1] | (QUO_W'(1) << BIT);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= r_den[k-1];
                r_q[k]   <= n_q;
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    localparam logic [QUO_W-1:0] MAX_POS = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] MIN_NEG = {1'b1, {(QUO_W-1){1'b0}}};

    always_comb begin
        if (r_ovf[QUO_W]) begin
            o_quo = r_neg[QUO_W] ? MIN_NEG : MAX_POS;
        end else if (!r_neg[QUO_W]) begin
            o_quo = r_q[QUO_W][QUO_W-1] ? MAX_POS : r_q[QUO_W];
        end else begin
            o_quo = (r_q[QUO_W] > MIN_NEG) ? MIN_NEG : (~r_q[QUO_W] + QUO_W'(1));
        end
    end

endmodule

FILE: hdl/quintic_trajectory_coeffs.sv
// ============================================================================
// quintic_trajectory_coeffs: jerk-minimizing quintic coefficient engine
// Turns start/goal states and a duration into six Q32.32 coefficients.
// ============================================================================
// Usage:
//   i_in carries one transaction per trajectory: start and goal position,
//   velocity and acceleration (signed, IN_FRAC_BITS fraction bits) and the
//   unsigned duration T. o_out returns coef_0..coef_5 (signed, OUT_FRAC_BITS
//   fraction bits) and invalid, which is set with all-zero coefficients when
//   T is zero. Coefficients 3 to 5 are truncated toward zero and saturated.
//   From the accepting edge to o_out.valid, seven front stages build T^3,
//   T^4, T^5 and the numerators, then three dividers resolve one quotient
//   bit per stage over 64 stages, and the output register holds the result.
//   Throughput is one transaction per cycle; i_in.ready stays high unless a
//   result waits in the output register while o_out.ready is low, in which
//   case the whole pipeline holds and nothing is dropped or repeated.
//   Reset clears the valid bits only; the pipeline contents need none.
// ============================================================================
module quintic_trajectory_coeffs #(
    parameter int IN_FRAC_BITS  = qtc_pkg::IN_FRAC_BITS_DEFAULT,
    parameter int OUT_FRAC_BITS = qtc_pkg::OUT_FRAC_BITS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qtc_in_if.sink    i_in,
    qtc_out_if.source o_out
);

    localparam int F     = IN_FRAC_BITS;
    localparam int G     = OUT_FRAC_BITS;
    localparam int IW    = qtc_pkg::IN_W;
    localparam int TW    = qtc_pkg::DUR_W;
    localparam int CW    = qtc_pkg::COEF_W;
    localparam int QW    = qtc_pkg::QUO_W;
    localparam int LO_W  = (TW + 1) / 2;
    localparam int HI_W  = TW - LO_W;
    localparam int DW    = IW + 1;
    localparam int PW    = IW + TW;
    localparam int DPW   = DW + TW;
    localparam int S2W   = IW + 2 * TW;
    localparam int RDW   = DW + 2 * TW;
    localparam int T2W   = 2 * TW;
    localparam int T3W   = 3 * TW;
    localparam int T4W   = 4 * TW;
    localparam int T5W   = 5 * TW;
    localparam int MW    = qtc_pkg::imax(qtc_pkg::imax(IW + 2 * F + 2, IW + TW + F + 1),
                                         IW + 2 * TW + 1) + 2;
    localparam int MMW   = MW + 5;
    localparam int FRONT = 7;
    localparam int LAT   = FRONT + 1 + QW;

    logic r_out_valid;
    logic en;
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    // Valid bits and sideband travel with each item through every stage.
    logic [LAT-1:0]      r_vld;
    qtc_pkg::t_side      r_sb [0:LAT-1];
    qtc_pkg::t_side      in_sb;

    assign in_sb = '{sp: i_in.start_position, sv: i_in.start_velocity,
                     sa: i_in.start_accel, dur: i_in.duration};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= in_sb;
            for (int k = 1; k < LAT; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // Stage 1: differences of the boundary states.
    logic signed [DW-1:0] r1_dp, r1_dv, r1_da;
    // Stage 2: first products with T.
    logic signed [PW-1:0]  r2_a, r2_b;
    logic signed [DPW-1:0] r2_c, r2_e;
    logic signed [DW-1:0]  r2_dp;
    logic [T2W-1:0]        r2_t2;
    // Stage 3: split products for the T^2 terms, and T^3.
    logic signed [S2W-1:0] r3_sal, r3_sah;
    logic signed [RDW-1:0] r3_rdl, r3_rdh;
    logic signed [PW-1:0]  r3_b;
    logic signed [DPW-1:0] r3_c;
    logic signed [DW-1:0]  r3_dp;
    logic [T3W-1:0]        r3_t3;
    // Stage 4: T^2 terms summed, T^4 partials.
    logic signed [S2W-1:0] r4_sat2;
    logic signed [RDW-1:0] r4_rd;
    logic signed [PW-1:0]  r4_b;
    logic signed [DPW-1:0] r4_c;
    logic signed [DW-1:0]  r4_dp;
    logic [T3W-1:0]        r4_t3;
    logic [T4W-1:0]        r4_t4l, r4_t4h;
    // Stage 5: residuals scaled by 2^(3F+1).
    logic signed [MW-1:0]  r5_n0, r5_qd, r5_rd;
    logic [T3W-1:0]        r5_t3;
    logic [T4W-1:0]        r5_t4;
    // Stage 6: coefficient numerators, T^5 partials.
    logic signed [MMW-1:0] r6_m3, r6_m4, r6_m5;
    logic [T3W-1:0]        r6_t3;
    logic [T4W-1:0]        r6_t4;
    logic [T5W-1:0]        r6_t5l, r6_t5h;
    // Stage 7: magnitudes, signs and denominators for the dividers.
    logic [MMW-1:0]        r7_mag3, r7_mag4, r7_mag5;
    logic                  r7_neg3, r7_neg4, r7_neg5;
    logic [T3W:0]          r7_den3;
    logic [T4W-1:0]        r7_den4;
    logic [T5W-1:0]        r7_den5;

    logic signed [TW:0]    t2s;
    logic [LO_W-1:0]       t3lo;
    logic [HI_W-1:0]       t3hi;
    logic [LO_W-1:0]       t4lo;
    logic [HI_W-1:0]       t4hi;
    logic [LO_W-1:0]       t6lo;
    logic [HI_W-1:0]       t6hi;

    assign t2s  = $signed({1'b0, r_sb[0].dur});
    assign t3lo = r_sb[1].dur[LO_W-1:0];
    assign t3hi = r_sb[1].dur[TW-1:LO_W];
    assign t4lo = r_sb[2].dur[LO_W-1:0];
    assign t4hi = r_sb[2].dur[TW-1:LO_W];
    assign t6lo = r_sb[4].dur[LO_W-1:0];
    assign t6hi = r_sb[4].dur[TW-1:LO_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dp <= DW'(i_in.goal_position) - DW'(i_in.start_position);
            r1_dv <= DW'(i_in.goal_velocity) - DW'(i_in.start_velocity);
            r1_da <= DW'(i_in.goal_accel) - DW'(i_in.start_accel);

            r2_a  <= PW'(r_sb[0].sa) * PW'(t2s);
            r2_b  <= PW'(r_sb[0].sv) * PW'(t2s);
            r2_c  <= DPW'(r1_dv) * DPW'(t2s);
            r2_e  <= DPW'(r1_da) * DPW'(t2s);
            r2_dp <= r1_dp;
            r2_t2 <= T2W'(r_sb[0].dur) * T2W'(r_sb[0].dur);

            r3_sal <= S2W'(r2_a) * S2W'($signed({1'b0, t3lo}));
            r3_sah <= S2W'(r2_a) * S2W'($signed({1'b0, t3hi}));
            r3_rdl <= RDW'(r2_e) * RDW'($signed({1'b0, t3lo}));
            r3_rdh <= RDW'(r2_e) * RDW'($signed({1'b0, t3hi}));
            r3_b   <= r2_b;
            r3_c   <= r2_c;
            r3_dp  <= r2_dp;
            r3_t3  <= T3W'(r2_t2) * T3W'(r_sb[1].dur);

            r4_sat2 <= r3_sal + (r3_sah <<< LO_W);
            r4_rd   <= r3_rdl + (r3_rdh <<< LO_W);
            r4_b    <= r3_b;
            r4_c    <= r3_c;
            r4_dp   <= r3_dp;
            r4_t3   <= r3_t3;
            r4_t4l  <= T4W'(r3_t3) * T4W'(t4lo);
            r4_t4h  <= T4W'(r3_t3) * T4W'(t4hi);

            r5_n0 <= (MW'(r4_dp) <<< (2 * F + 1)) - (MW'(r4_b) <<< (F + 1)) - MW'(r4_sat2);
            r5_qd <= (MW'(r4_c) <<< F) - MW'(r4_sat2);
            r5_rd <= MW'(r4_rd);
            r5_t3 <= r4_t3;
            r5_t4 <= r4_t4l + (r4_t4h << LO_W);

            // m3 = 10 n0 - 8 qd + rd, m4 = 14 qd - 15 n0 - 2 rd, m5 = 6 n0 - 6 qd + rd.
            r6_m3 <= (MMW'(r5_n0) <<< 3) + (MMW'(r5_n0) <<< 1) - (MMW'(r5_qd) <<< 3)
                     + MMW'(r5_rd);
            r6_m4 <= (MMW'(r5_qd) <<< 4) - (MMW'(r5_qd) <<< 1) - (MMW'(r5_n0) <<< 4)
                     + MMW'(r5_n0) - (MMW'(r5_rd) <<< 1);
            r6_m5 <= (MMW'(r5_n0) <<< 2) + (MMW'(r5_n0) <<< 1) - (MMW'(r5_qd) <<< 2)
                     - (MMW'(r5_qd) <<< 1) + MMW'(r5_rd);
            r6_t3  <= r5_t3;
            r6_t4  <= r5_t4;
            r6_t5l <= T5W'(r5_t4) * T5W'(t6lo);
            r6_t5h <= T5W'(r5_t4) * T5W'(t6hi);

            r7_neg3 <= r6_m3[MMW-1];
            r7_neg4 <= r6_m4[MMW-1];
            r7_neg5 <= r6_m5[MMW-1];
            r7_mag3 <= r6_m3[MMW-1] ? -r6_m3 : r6_m3;
            r7_mag4 <= r6_m4[MMW-1] ? -r6_m4 : r6_m4;
            r7_mag5 <= r6_m5[MMW-1] ? -r6_m5 : r6_m5;
            r7_den3 <= {r6_t3, 1'b0};
            r7_den4 <= r6_t4;
            r7_den5 <= r6_t5l + (r6_t5h << LO_W);
        end
    end

    logic signed [CW-1:0] quo3, quo4, quo5;

    qtc_div #(.NUM_W(MMW + G), .DEN_W(T3W + 1), .QUO_W(QW)) u_div3 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag ({r7_mag3, {G{1'b0}}}),
        .i_neg (r7_neg3),
        .i_den (r7_den3),
        .o_quo (quo3)
    );

    qtc_div #(.NUM_W(MMW + F + G - 1), .DEN_W(T4W), .QUO_W(QW)) u_div4 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag ({r7_mag4, {(F + G - 1){1'b0}}}),
        .i_neg (r7_neg4),
        .i_den (r7_den4),
        .o_quo (quo4)
    );

    qtc_div #(.NUM_W(MMW + 2 * F + G - 1), .DEN_W(T5W), .QUO_W(QW)) u_div5 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag ({r7_mag5, {(2 * F + G - 1){1'b0}}}),
        .i_neg (r7_neg5),
        .i_den (r7_den5),
        .o_quo (quo5)
    );

    // Output register.
    logic signed [CW-1:0] r_coef0, r_coef1, r_coef2, r_coef3, r_coef4, r_coef5;
    logic                 r_invalid;
    logic                 zero_t;

    assign zero_t = (r_sb[LAT-1].dur == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_invalid <= zero_t;
            if (zero_t) begin
                r_coef0 <= '0;
                r_coef1 <= '0;
                r_coef2 <= '0;
                r_coef3 <= '0;
                r_coef4 <= '0;
                r_coef5 <= '0;
            end else begin
                r_coef0 <= qtc_pkg::scale_fix(r_sb[LAT-1].sp, G - F);
                r_coef1 <= qtc_pkg::scale_fix(r_sb[LAT-1].sv, G - F);
                r_coef2 <= qtc_pkg::scale_fix(r_sb[LAT-1].sa, G - F - 1);
                r_coef3 <= quo3;
                r_coef4 <= quo4;
                r_coef5 <= quo5;
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.coef_0  = r_coef0;
    assign o_out.coef_1  = r_coef1;
    assign o_out.coef_2  = r_coef2;
    assign o_out.coef_3  = r_coef3;
    assign o_out.coef_4  = r_coef4;
    assign o_out.coef_5  = r_coef5;
    assign o_out.invalid = r_invalid;

endmodule

FILE: verif/quintic_trajectory_coeffs_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// quintic_trajectory_coeffs_tb: self-checking bench for the quintic engine
// Sends boundary-state transactions with random pauses on both channels and
// predicts every coefficient with exact wide arithmetic. It also checks
// zero duration, saturation, full back-pressure and a full drain.
// ============================================================================
module quintic_trajectory_coeffs_tb;

    localparam int FRAC_IN     = qtc_pkg::IN_FRAC_BITS_DEFAULT;
    localparam int FRAC_OUT    = qtc_pkg::OUT_FRAC_BITS_DEFAULT;
    localparam int DUR_BITS    = qtc_pkg::DUR_W;
    localparam int LATENCY     = 72;
    localparam int MAX_CYCLE   = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [qtc_pkg::DUR_W-1:0] DUR_TOP = '1;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic signed [31:0]        sp;
        logic signed [31:0]        sv;
        logic signed [31:0]        sa;
        logic signed [31:0]        gp;
        logic signed [31:0]        gv;
        logic signed [31:0]        ga;
        logic [qtc_pkg::DUR_W-1:0] dur;
    } traj_t;

    typedef struct packed {
        logic [5:0][63:0] c;
        logic             inv;
    } coefs_t;

    logic clk;
    logic rst_n;
    int   cycle_cnt;
    int   err_cnt;
    int   sent_cnt;
    int   recv_cnt;
    int   sat_cnt;
    int   zero_dur_cnt;
    bit   idle_on;
    int   hold_req;
    coefs_t pending_coefs[$];

    qtc_in_if  in_ch();
    qtc_out_if out_ch();

    quintic_trajectory_coeffs u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #10 clk = ~clk;

    function automatic logic [63:0] clamp64(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = wide_t'(64'h7FFF_FFFF_FFFF_FFFF);
        lo = -(wide_t'(1) <<< 63);
        if (v > hi) return hi[63:0];
        if (v < lo) return lo[63:0];
        return v[63:0];
    endfunction

    // Exact rational evaluation, truncated toward zero by signed division.
    function automatic coefs_t solve_quintic(input traj_t x);
        wide_t sp, sv, sa, gp, gv, ga, t, sat2, n0, qd, rd, m3, m4, m5, t3, t4, t5;
        coefs_t r;
        r = '0;
        if (x.dur == 0) begin
            r.inv = 1'b1;
            return r;
        end
        sp = x.sp; sv = x.sv; sa = x.sa;
        gp = x.gp; gv = x.gv; ga = x.ga;
        t  = x.dur;
        r.c[0] = clamp64((sp <<< FRAC_OUT) / (wide_t'(1) <<< FRAC_IN));
        r.c[1] = clamp64((sv <<< FRAC_OUT) / (wide_t'(1) <<< FRAC_IN));
        r.c[2] = clamp64((sa <<< FRAC_OUT) / (wide_t'(1) <<< (FRAC_IN + 1)));
        sat2 = sa * t * t;
        n0 = ((gp - sp) <<< (2 * FRAC_IN + 1)) - ((sv * t) <<< (FRAC_IN + 1)) - sat2;
        qd = (((gv - sv) * t) <<< FRAC_IN) - sat2;
        rd = (ga - sa) * t * t;
        m3 = n0 * 10 - qd * 8 + rd;
        m4 = qd * 14 - n0 * 15 - rd * 2;
        m5 = n0 * 6 - qd * 6 + rd;
        t3 = t * t * t;
        t4 = t3 * t;
        t5 = t4 * t;
        r.c[3] = clamp64((m3 <<< FRAC_OUT) / (t3 * 2));
        r.c[4] = clamp64((m4 <<< (FRAC_IN + FRAC_OUT - 1)) / t4);
        r.c[5] = clamp64((m5 <<< (2 * FRAC_IN + FRAC_OUT - 1)) / t5);
        return r;
    endfunction

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 2000)) - 1000;
            1: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic traj_t rand_traj();
        traj_t x;
        int    pick;
        x.sp = rand_val(); x.sv = rand_val(); x.sa = rand_val();
        x.gp = rand_val(); x.gv = rand_val(); x.ga = rand_val();
        pick = $urandom_range(0, 99);
        if (pick < 3)       x.dur = '0;
        else if (pick < 35) x.dur = DUR_BITS'($urandom_range(1, 2 << FRAC_IN));
        else if (pick < 85) x.dur = DUR_BITS'($urandom_range(1, 4194304));
        else                x.dur = DUR_BITS'($urandom_range(4194305, DUR_TOP));
        return x;
    endfunction

    // Offers one transaction and waits for the edge that accepts it; with idle_on it may then pause.
    task automatic send_traj(input traj_t x);
        in_ch.valid          <= 1'b1;
        in_ch.start_position <= x.sp;
        in_ch.start_velocity <= x.sv;
        in_ch.start_accel    <= x.sa;
        in_ch.goal_position  <= x.gp;
        in_ch.goal_velocity  <= x.gv;
        in_ch.goal_accel     <= x.ga;
        in_ch.duration       <= x.dur;
        do @(posedge clk); while (!in_ch.ready);
        pending_coefs.insert(pending_coefs.size(), solve_quintic(x));
        sent_cnt++;
        if (x.dur == 0) zero_dur_cnt++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic pause_sender();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_coefs.size() != 0) @(posedge clk);
    endtask

    // Receiver: random stall bursts, or one long hold-off for each new request.
    always @(posedge clk) begin
        static int stall_left = 0;
        static int hold_left  = 0;
        static int hold_seen  = 0;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else if (hold_seen != hold_req) begin
            out_ch.ready <= 1'b0;
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES - 1;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 9);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Compares each transaction on the result channel with the oldest prediction.
    always @(posedge clk) begin
        coefs_t exp_c;
        logic [5:0][63:0] got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.coef_5, out_ch.coef_4, out_ch.coef_3,
                   out_ch.coef_2, out_ch.coef_1, out_ch.coef_0};
            if (pending_coefs.size() == 0) begin
                $error("unexpected result transaction");
                err_cnt++;
            end else begin
                exp_c = pending_coefs.pop_front();
                recv_cnt++;
                for (int k = 0; k < 6; k++) begin
                    if (exp_c.c[k] == 64'h7FFF_FFFF_FFFF_FFFF ||
                        exp_c.c[k] == 64'h8000_0000_0000_0000) sat_cnt++;
                    if (got[k] !== exp_c.c[k]) begin
                        $error("coef_%0d: expected %0d, got %0d", k,
                               $signed(exp_c.c[k]), $signed(got[k]));
                        err_cnt++;
                    end
                end
                if (out_ch.invalid !== exp_c.inv) begin
                    $error("invalid: expected %0d, got %0d", exp_c.inv, out_ch.invalid);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_boundaries();
        traj_t x;
        logic signed [31:0] ext[4];
        ext = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF};
        // Zero duration with nonzero states must still give all-zero coefficients.
        x = '{ext[0], ext[1], ext[0], ext[1], ext[0], ext[1], '0};
        send_traj(x);
        x = '{32'sh0001_0000, 32'sh0002_0000, 32'sh0001_8000,
              32'sh000A_0000, 32'sh0000_0000, 32'sh0000_0000, 23'(1 << FRAC_IN)};
        send_traj(x);
        for (int k = 0; k < 4; k++) begin
            x = '{ext[k], ext[(k + 1) % 4], ext[(k + 2) % 4],
                  ext[(k + 3) % 4], ext[k], ext[(k + 1) % 4], 23'd1};
            send_traj(x);
            x.dur = DUR_TOP;
            send_traj(x);
            x.dur = 23'd4194304;
            send_traj(x);
        end
        // Largest residuals in both directions at the shortest duration saturate.
        x = '{ext[1], ext[0], ext[1], ext[0], ext[1], ext[0], 23'd1};
        send_traj(x);
        x = '{ext[0], ext[1], ext[0], ext[1], ext[0], ext[1], 23'd1};
        send_traj(x);
        x = '{ext[3], ext[3], ext[3], ext[2], ext[2], ext[2], 23'd3};
        send_traj(x);
        x = '{ext[2], ext[2], ext[2], ext[2], ext[2], ext[2], 23'd1 << 22};
        send_traj(x);
        pause_sender();
        wait_drained();
    endtask

    task automatic test_random(input int n);
        for (int k = 0; k < n; k++) send_traj(rand_traj());
        pause_sender();
    endtask

    task automatic test_backpressure();
        bit saved;
        saved   = idle_on;
        idle_on = 0;
        @(posedge clk);
        hold_req <= hold_req + 1;
        for (int k = 0; k < 200; k++) send_traj(rand_traj());
        pause_sender();
        idle_on = saved;
    endtask

    task automatic test_drain_pause();
        test_random(20);
        wait_drained();
        test_random(20);
    endtask

    initial begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        idle_on  = 1;
        hold_req = 0;
        in_ch.valid          = 1'b0;
        in_ch.start_position = '0;
        in_ch.start_velocity = '0;
        in_ch.start_accel    = '0;
        in_ch.goal_position  = '0;
        in_ch.goal_velocity  = '0;
        in_ch.goal_accel     = '0;
        in_ch.duration       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_boundaries();
        test_random(500);
        test_backpressure();
        test_drain_pause();
        idle_on = 0;
        test_random(380);

        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);
        $display("%0d trajectories sent, %0d results checked, %0d with zero duration,",
                 sent_cnt, recv_cnt, zero_dur_cnt);
        $display("%0d saturated coefficients, long output hold-off and full drain done",
                 sat_cnt);
        if (err_cnt == 0 && pending_coefs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
